FILE: src/kvt_pkg.sv
// Package for the keyed value table: sizes, command and status codes,
// and the result record passed from the sequencer to the output stage.
// No dependencies.
package kvt_pkg;

    localparam int DEPTH      = 32;   // table capacity, 2 to 63 (counts are reported in 6 bits)
    localparam int KEY_BITS   = 16;   // stored key width, 1 to 16 on this port
    localparam int VALUE_BITS = 32;   // stored value width, 1 to 32 on this port

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    localparam int CMD_W   = 3;
    localparam int IKEY_W  = 16;
    localparam int IVAL_W  = 32;
    localparam int OCNT_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OCNT_W-1:0] entry_count;
        logic [OCNT_W-1:0] match_count;
        logic [IVAL_W-1:0] read_value;
        logic              found;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } t_ram_req;

endpackage

FILE: src/kvt_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data, ready in the cycle after the read. No dependencies.
module kvt_ram #(
    parameter int WIDTH   = 48,
    parameter int DEPTH_P = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH_P)-1:0] i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH_P)-1:0] i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH_P];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/kvt_ctrl.sv
// Command sequencer for the keyed value table: scans the entry RAM where
// needed, then updates it and builds the result. Depends on kvt_pkg.
module kvt_ctrl import kvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [IKEY_W-1:0]  i_key,
    input  logic [IVAL_W-1:0]  i_value,
    output t_ram_req           o_ram,
    input  logic [ENTRY_W-1:0] i_rdata,
    output logic               o_res_valid,
    input  logic               i_res_take,
    output t_result            o_res
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_FINISH  = 3'd2;
    localparam logic [2:0] S_MOVE_RD = 3'd3;
    localparam logic [2:0] S_MOVE_WR = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]            r_state,   n_state;
    logic [CMD_W-1:0]      r_cmd,     n_cmd;
    logic [KEY_BITS-1:0]   r_key,     n_key;
    logic [VALUE_BITS-1:0] r_val,     n_val;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [CNT_W-1:0]      r_issue,   n_issue;
    logic                  r_pend,    n_pend;
    logic [IDX_W-1:0]      r_chk,     n_chk;
    logic                  r_hit,     n_hit;
    logic [IDX_W-1:0]      r_slot,    n_slot;
    logic [VALUE_BITS-1:0] r_hit_val, n_hit_val;
    logic [CNT_W-1:0]      r_match,   n_match;
    t_result               r_res,     n_res;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic [CNT_W-1:0]      last_cnt;
    logic                  full;

    assign rd_key   = i_rdata[ENTRY_W-1:VALUE_BITS];
    assign rd_val   = i_rdata[VALUE_BITS-1:0];
    assign last_cnt = r_count - 1'b1;
    assign full     = (r_count >= CNT_W'(DEPTH));

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res             = r_res;
        o_res.entry_count = OCNT_W'(r_count);
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_val     = r_val;
        n_count   = r_count;
        n_issue   = r_issue;
        n_pend    = r_pend;
        n_chk     = r_chk;
        n_hit     = r_hit;
        n_slot    = r_slot;
        n_hit_val = r_hit_val;
        n_match   = r_match;
        n_res     = r_res;
        o_ram     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    n_key     = i_key[KEY_BITS-1:0];
                    n_val     = i_value[VALUE_BITS-1:0];
                    n_issue   = '0;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_hit_val = '0;
                    n_match   = '0;
                    n_res     = '0;
                    // skip the scan where its outcome does not matter
                    if ((i_cmd == CMD_INSERT && !full) || i_cmd == CMD_REMOVE
                        || i_cmd == CMD_LOOKUP || i_cmd == CMD_COUNT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                // issue one read a cycle, check the word read the cycle before
                if (r_issue < r_count) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = r_issue[IDX_W-1:0];
                    n_issue     = r_issue + 1'b1;
                    n_chk       = r_issue[IDX_W-1:0];
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FINISH;
                    end
                end
                if (r_pend) begin
                    if (rd_key == r_key) begin
                        n_hit     = 1'b1;
                        n_slot    = r_chk;
                        n_hit_val = rd_val;
                    end
                    if (rd_val == r_val) begin
                        n_match = r_match + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_count = '0;
                    end
                    CMD_INSERT: begin
                        if (full) begin
                            n_res.status = ST_FULL;
                        end else if (r_hit) begin
                            n_res.status = ST_DUP;
                        end else begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = r_count[IDX_W-1:0];
                            o_ram.wdata = {r_key, r_val};
                            n_count     = r_count + 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_hit) begin
                            n_res.found = 1'b1;
                            n_state     = S_MOVE_RD;
                        end
                    end
                    CMD_LOOKUP: begin
                        n_res.found      = r_hit;
                        n_res.read_value = IVAL_W'(r_hit_val);
                    end
                    CMD_COUNT: begin
                        n_res.match_count = OCNT_W'(r_match);
                    end
                    default: begin
                    end
                endcase
            end
            S_MOVE_RD: begin
                // fetch the last entry to fill the hole
                o_ram.re    = 1'b1;
                o_ram.raddr = last_cnt[IDX_W-1:0];
                n_state     = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_slot;
                o_ram.wdata = i_rdata;
                n_count     = last_cnt;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_val     <= n_val;
        r_issue   <= n_issue;
        r_pend    <= n_pend;
        r_chk     <= n_chk;
        r_hit     <= n_hit;
        r_slot    <= n_slot;
        r_hit_val <= n_hit_val;
        r_match   <= n_match;
        r_res     <= n_res;
    end

endmodule

FILE: src/keyed_value_table_unit.sv
// Top level of the keyed value table: entry RAM, command sequencer and
// output register. Depends on kvt_pkg, kvt_ram and kvt_ctrl.
//
//  channel   dir  tvalid/tready          tdata / tuser
//  --------  ---  ---------------------  ------------------------------------
//  command   in   i_s_tvalid/o_s_tready  tuser cmd; tdata key, value
//  result    out  o_m_tvalid/i_m_tready  tdata found, read_value, match_count,
//                                        entry_count, status
//
// One command at a time. Insert, remove, lookup and count read every stored
// entry in turn through the single read port of the entry RAM before the
// result is offered; remove of a present key then moves the last entry into
// the freed slot. Clear, unused codes and insert into a full table skip the scan.
// Reset clears the entry count and the sequencer; stored words stay as left.
// The result register lets the next command transfer in while a result
// stalls; the sequencer holds in its last state only if a second result is
// ready before the first is taken.
module keyed_value_table_unit import kvt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] item_key, [47:16] item_value
    input  logic [2:0]  i_s_tuser,   // [2:0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // [0] found, [32:1] read_value,
                                     // [38:33] match_count, [44:39] entry_count,
                                     // [46:45] status, [47] zero
);

    t_ram_req           ram_req;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               res_valid;
    logic               res_take;
    t_result            res;

    logic    r_out_valid;
    t_result r_out;

    kvt_ram #(
        .WIDTH   (ENTRY_W),
        .DEPTH_P (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    kvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_tvalid),
        .o_cmd_ready (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_key       (i_s_tdata[15:0]),
        .i_value     (i_s_tdata[47:16]),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // load the result register when it is empty or being drained this cycle
    assign res_take = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

endmodule
